>>> rtl/apdu_pkg.sv
// ----------------------------------------------------------------------------
// apdu_pkg
// Shared types and constants for the command APDU parser.
// ----------------------------------------------------------------------------
package apdu_pkg;

  localparam int unsigned POS_W = 17;
  localparam int unsigned LEN_W = 16;

  localparam logic [POS_W-1:0] POS_MAX      = '1;
  localparam logic [POS_W-1:0] HDR_BYTES    = 17'd4;
  localparam logic [POS_W-1:0] LC_POS       = 17'd4;
  localparam logic [POS_W-1:0] SHORT_DATA   = 17'd5;
  localparam logic [POS_W-1:0] EXT_LC_POS   = 17'd6;
  localparam logic [POS_W-1:0] EXT_DATA     = 17'd7;

  localparam logic [POS_W:0]   LEN_CASE1    = 18'd4;
  localparam logic [POS_W:0]   LEN_CASE2S   = 18'd5;
  localparam logic [POS_W:0]   LEN_EXT_BAD  = 18'd6;
  localparam logic [POS_W:0]   LEN_CASE2E   = 18'd7;
  localparam logic [POS_W:0]   EXT_LE_OVH   = 18'd9;

  localparam logic [7:0]       EXT_MARK     = 8'h00;

  localparam logic             KIND_DATA    = 1'b0;
  localparam logic             KIND_SUMMARY = 1'b1;
  localparam logic             STATUS_OK    = 1'b0;
  localparam logic             STATUS_WRONG = 1'b1;

  // One entry per accepted byte that produces output.
  typedef struct packed {
    logic             data;
    logic [7:0]       data_byte;
    logic             summ;
    logic [31:0]      header;
    logic [LEN_W-1:0] lc;
    logic [LEN_W-1:0] le;
    logic             le_present;
    logic             bad;
  } apdu_rec_t;

  function automatic logic lc_bad(input logic [LEN_W-1:0] lc,
                                  input logic [LEN_W-1:0] max_len);
    lc_bad = (lc == '0) || (lc > max_len);
  endfunction

endpackage

>>> rtl/apdu_front.sv
// ----------------------------------------------------------------------------
// apdu_front
// Byte parser: tracks header, length fields and position, and classifies each
// incoming byte into a data record and/or an end-of-frame summary record.
// ----------------------------------------------------------------------------
module apdu_front import apdu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       in_byte,
  input  logic             frame_end,
  input  logic [LEN_W-1:0] max_data_length,
  input  logic             q_full,
  output logic             q_push,
  output apdu_rec_t        q_rec
);

  logic [POS_W-1:0] byte_position;
  logic [31:0]      header_bytes;
  logic             extended_mode;
  logic [LEN_W-1:0] length_field;
  logic [7:0]       previous_byte;
  logic             length_error;

  logic [31:0]      hdr_next;
  logic             ext_next;
  logic [LEN_W-1:0] lf_next;
  logic             err_next;
  logic [LEN_W-1:0] ext_word;
  logic             data;
  logic [POS_W:0]   len;
  logic [POS_W:0]   lc_wide;
  logic [LEN_W-1:0] lc;
  logic [LEN_W-1:0] le;
  logic             present;
  logic             bad;
  logic             accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    hdr_next = header_bytes;
    ext_next = extended_mode;
    lf_next  = length_field;
    err_next = length_error;
    ext_word = {previous_byte, in_byte};
    data     = 1'b0;

    if (byte_position < HDR_BYTES) begin
      case (byte_position[1:0])
        2'd0:    hdr_next[31:24] = in_byte;
        2'd1:    hdr_next[23:16] = in_byte;
        2'd2:    hdr_next[15:8]  = in_byte;
        default: hdr_next[7:0]   = in_byte;
      endcase
    end

    if (byte_position == LC_POS && !frame_end) begin
      if (in_byte == EXT_MARK) begin
        ext_next = 1'b1;
      end else begin
        lf_next = {8'd0, in_byte};
        if (lc_bad({8'd0, in_byte}, max_data_length)) err_next = 1'b1;
      end
    end

    if (!ext_next) begin
      data = (byte_position >= SHORT_DATA) &&
             (byte_position <= ({1'b0, lf_next} + HDR_BYTES)) && !err_next;
    end else begin
      if (byte_position == EXT_LC_POS) begin
        lf_next = ext_word;
        if (!frame_end && lc_bad(ext_word, max_data_length)) err_next = 1'b1;
      end
      data = (byte_position >= EXT_DATA) &&
             (byte_position <= ({1'b0, lf_next} + EXT_LC_POS)) && !err_next;
    end
  end

  // End-of-frame length check
  always_comb begin
    len     = {1'b0, byte_position} + 18'd1;
    lc_wide = {2'b00, lf_next};
    lc      = '0;
    le      = '0;
    present = 1'b0;
    bad     = 1'b0;
    if (len < LEN_CASE1) begin
      bad = 1'b1;
    end else if (len == LEN_CASE1) begin
      bad = 1'b0;
    end else if (len == LEN_CASE2S) begin
      le      = {8'd0, in_byte};
      present = 1'b1;
    end else if (!ext_next) begin
      lc = lf_next;
      if (err_next) begin
        bad = 1'b1;
      end else if (len == lc_wide + LEN_CASE2S) begin
        bad = 1'b0;
      end else if (len == lc_wide + LEN_EXT_BAD) begin
        le      = {8'd0, in_byte};
        present = 1'b1;
      end else begin
        bad = 1'b1;
      end
    end else if (len == LEN_EXT_BAD) begin
      bad = 1'b1;
    end else if (len == LEN_CASE2E) begin
      le      = ext_word;
      present = 1'b1;
    end else begin
      lc = lf_next;
      if (err_next) begin
        bad = 1'b1;
      end else if (len == lc_wide + LEN_CASE2E) begin
        bad = 1'b0;
      end else if (len == lc_wide + EXT_LE_OVH) begin
        le      = ext_word;
        present = 1'b1;
      end else begin
        bad = 1'b1;
      end
    end
    if (bad) begin
      le      = '0;
      present = 1'b0;
      lc      = (len < LEN_EXT_BAD) ? '0 : lf_next;
    end
  end

  always_comb begin
    q_push           = accept && (data || frame_end);
    q_rec.data       = data;
    q_rec.data_byte  = in_byte;
    q_rec.summ       = frame_end;
    q_rec.header     = hdr_next;
    q_rec.lc         = lc;
    q_rec.le         = le;
    q_rec.le_present = present;
    q_rec.bad        = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      header_bytes  <= '0;
      extended_mode <= 1'b0;
      length_field  <= '0;
      previous_byte <= '0;
      length_error  <= 1'b0;
    end else if (accept) begin
      if (frame_end) begin
        byte_position <= '0;
        header_bytes  <= '0;
        extended_mode <= 1'b0;
        length_field  <= '0;
        previous_byte <= '0;
        length_error  <= 1'b0;
      end else begin
        header_bytes  <= hdr_next;
        extended_mode <= ext_next;
        length_field  <= lf_next;
        length_error  <= err_next;
        previous_byte <= in_byte;
        if (byte_position != POS_MAX) byte_position <= byte_position + 17'd1;
      end
    end
  end

endmodule

>>> rtl/apdu_rec_fifo.sv
// ----------------------------------------------------------------------------
// apdu_rec_fifo
// Small record queue between the parser and the result stage.
// ----------------------------------------------------------------------------
module apdu_rec_fifo import apdu_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  apdu_rec_t wr_rec,
  output logic      q_full,
  input  logic      rd_en,
  output apdu_rec_t rd_rec,
  output logic      q_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  apdu_rec_t        mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (count == CNT_W'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_rec  = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      if (do_rd) rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/apdu_back.sv
// ----------------------------------------------------------------------------
// apdu_back
// Result stage: holds one record and presents its data byte and/or summary
// as queue-style results, one transfer per cycle while pop is high.
// ----------------------------------------------------------------------------
module apdu_back import apdu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  apdu_rec_t        q_rec,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic             kind,
  output logic [7:0]       payload_byte,
  output logic [7:0]       class_byte,
  output logic [7:0]       instruction_byte,
  output logic [7:0]       param_one,
  output logic [7:0]       param_two,
  output logic [LEN_W-1:0] data_length,
  output logic [LEN_W-1:0] expected_length,
  output logic             expected_present,
  output logic             status,
  output logic             last_result
);

  apdu_rec_t cur;
  logic      cur_valid;
  logic      data_done;
  logic      show_data;
  logic      take;
  logic      release_rec;

  assign show_data   = cur.data && !data_done;
  assign take        = pop && cur_valid;
  assign release_rec = take && !(show_data && cur.summ);
  assign q_pop       = !q_empty && (!cur_valid || release_rec);
  assign empty       = !cur_valid;

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      data_done <= 1'b0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      data_done <= 1'b0;
    end else if (release_rec) begin
      cur_valid <= 1'b0;
      data_done <= 1'b0;
    end else if (take) begin
      data_done <= 1'b1;
    end
  end

  always_comb begin
    if (show_data) begin
      kind             = KIND_DATA;
      payload_byte     = cur.data_byte;
      class_byte       = '0;
      instruction_byte = '0;
      param_one        = '0;
      param_two        = '0;
      data_length      = '0;
      expected_length  = '0;
      expected_present = 1'b0;
      status           = STATUS_OK;
      last_result      = !cur.summ;
    end else begin
      kind             = KIND_SUMMARY;
      payload_byte     = '0;
      class_byte       = cur.header[31:24];
      instruction_byte = cur.header[23:16];
      param_one        = cur.header[15:8];
      param_two        = cur.header[7:0];
      data_length      = cur.lc;
      expected_length  = cur.le;
      expected_present = cur.le_present;
      status           = cur.bad ? STATUS_WRONG : STATUS_OK;
      last_result      = 1'b1;
    end
  end

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_SUMMARY) |-> last_result)
    else $error("summary result not marked last");

  a_data_then_summary: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && kind == KIND_DATA && !last_result) |=>
      (!empty && kind == KIND_SUMMARY))
    else $error("summary did not follow its data byte");

  a_error_no_le: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_SUMMARY && status == STATUS_WRONG) |->
      (!expected_present && expected_length == '0))
    else $error("wrong-length summary carries Le");

  a_no_load_while_split: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && show_data && cur.summ) |-> !q_pop)
    else $error("record replaced before its summary was taken");

endmodule

>>> rtl/apdu_command_parser_core.sv
// ----------------------------------------------------------------------------
// apdu_command_parser_core
// Streaming command APDU parser with queue-style byte input and result output.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle while full is low. Each byte yields zero,
// one or two results (a command data byte and/or the end-of-frame summary);
// the result side delivers one result per cycle while pop is high, so a last
// byte that is also a data byte takes two output transfers. A record queue of
// FIFO_DEPTH entries sits between the parser and the result register; a
// result passes through that queue and then the result register before it
// reaches the result ports. max_data_length sits at byte address 0 (reset 255).
module apdu_command_parser_core import apdu_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       in_byte,
  input  logic             frame_end,
  output logic             empty,
  input  logic             pop,
  output logic             kind,
  output logic [7:0]       payload_byte,
  output logic [7:0]       class_byte,
  output logic [7:0]       instruction_byte,
  output logic [7:0]       param_one,
  output logic [7:0]       param_two,
  output logic [LEN_W-1:0] data_length,
  output logic [LEN_W-1:0] expected_length,
  output logic             expected_present,
  output logic             status,
  output logic             last_result
);

  logic [LEN_W-1:0] max_data_length;
  logic             reg_hit;
  logic             q_full;
  logic             q_empty;
  logic             f_push;
  logic             b_pop;
  apdu_rec_t        f_rec;
  apdu_rec_t        b_rec;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'b0);
  assign prdata  = reg_hit ? {16'd0, max_data_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_data_length <= 16'd255;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_data_length <= pwdata[LEN_W-1:0];
    end
  end

  apdu_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .in_byte         (in_byte),
    .frame_end       (frame_end),
    .max_data_length (max_data_length),
    .q_full          (q_full),
    .q_push          (f_push),
    .q_rec           (f_rec)
  );

  apdu_rec_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_rec  (f_rec),
    .q_full  (q_full),
    .rd_en   (b_pop),
    .rd_rec  (b_rec),
    .q_empty (q_empty)
  );

  apdu_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_rec            (b_rec),
    .q_pop            (b_pop),
    .empty            (empty),
    .pop              (pop),
    .kind             (kind),
    .payload_byte     (payload_byte),
    .class_byte       (class_byte),
    .instruction_byte (instruction_byte),
    .param_one        (param_one),
    .param_two        (param_two),
    .data_length      (data_length),
    .expected_length  (expected_length),
    .expected_present (expected_present),
    .status           (status),
    .last_result      (last_result)
  );

endmodule

>>> sim/tb_apdu_command_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_apdu_command_parser_core
// Self-checking bench for the streaming command APDU parser.
// ----------------------------------------------------------------------------
// A short scripted run hits the header-only, Le-only, short data and extended
// corner frames. Random frames follow: mostly well-formed cases 1 to 4E with
// random content, plus truncated, padded and noise frames, under several
// max_data_length settings. Every result transfer is checked against a
// bench-side parser or, for typed script rows, a literal expected summary.
module tb_apdu_command_parser_core import apdu_pkg::*; ();

  localparam logic [2:0] MAX_LEN_ADDR = 3'd0;
  localparam int QUIET_CYCLES = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_BYTES = 175;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic [7:0]  cla;
    logic [7:0]  ins;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [15:0] lc;
    logic [15:0] le;
    logic        le_present;
    logic        status;
    logic        last;
  } apdu_result_t;

  // b, eof, typed, then the summary fields used when typed is set
  typedef struct packed {
    logic [7:0]  b;
    logic        eof;
    logic        typed;
    logic [7:0]  cla;
    logic [7:0]  ins;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [15:0] lc;
    logic [15:0] le;
    logic        lep;
    logic        st;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte = '0;
  logic        frame_end = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [7:0]  class_byte;
  logic [7:0]  instruction_byte;
  logic [7:0]  param_one;
  logic [7:0]  param_two;
  logic [15:0] data_length;
  logic [15:0] expected_length;
  logic        expected_present;
  logic        status;
  logic        last_result;

  apdu_command_parser_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .push             (push),
    .full             (full),
    .in_byte          (in_byte),
    .frame_end        (frame_end),
    .empty            (empty),
    .pop              (pop),
    .kind             (kind),
    .payload_byte     (payload_byte),
    .class_byte       (class_byte),
    .instruction_byte (instruction_byte),
    .param_one        (param_one),
    .param_two        (param_two),
    .data_length      (data_length),
    .expected_length  (expected_length),
    .expected_present (expected_present),
    .status           (status),
    .last_result      (last_result)
  );

  always #1 clk = ~clk;

  // bench-side parser state
  logic [15:0]  max_len = 16'd255;
  int           frame_pos = 0;
  logic [31:0]  hdr_bytes = '0;
  bit           ext_form = 1'b0;
  int           lc_field = 0;
  logic [7:0]   prev_byte = '0;
  bit           lc_error = 1'b0;

  apdu_result_t parsed_results[$];
  logic [7:0]   frame_q[$];

  int mismatches = 0;
  int results_seen = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int limits_used = 1;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_gap = 0;
  int hold_left = 0;
  int holds_done = 0;

  script_row_t script_rows [0:28] = '{
    '{8'hA5, 1'b1, 1'b1, 8'hA5, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_WRONG},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h80, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h7F, 1'b1, 1'b1, 8'hFF, 8'h00, 8'h80, 8'h7F, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'hA4, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h04, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'hFF, 1'b1, 1'b1, 8'h00, 8'hA4, 8'h04, 8'h00, 16'h0000, 16'h00FF, 1'b1, STATUS_OK},
    '{8'h80, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'hCA, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h02, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h5A, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'hB0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h12, 1'b1, 1'b1, 8'h00, 8'hB0, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_WRONG},
    '{8'h7F, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h80, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_OK},
    '{8'hFF, 1'b1, 1'b1, 8'h7F, 8'h01, 8'hFF, 8'h80, 16'h0000, 16'hFFFF, 1'b1, STATUS_OK}
  };

  function automatic int idle_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic bit lc_rejected(input int lc);
    return lc == 0 || lc > max_len;
  endfunction

  // Advances the parser by one byte and queues the results it produces when keep is set.
  task automatic parse_apdu_byte(input logic [7:0] b, input logic eof, input bit keep);
    int           p;
    int           flen;
    bit           data_hit;
    bit           bad;
    apdu_result_t r;
    p = frame_pos;
    if (p < 4) hdr_bytes = hdr_bytes | (32'(b) << (8 * (3 - p)));
    if (p == 4 && !eof) begin
      if (b == EXT_MARK) ext_form = 1'b1;
      else begin
        lc_field = int'(b);
        if (lc_rejected(lc_field)) lc_error = 1'b1;
      end
    end
    if (!ext_form) begin
      data_hit = p >= 5 && p <= 4 + lc_field && !lc_error;
    end else begin
      if (p == 6) begin
        lc_field = int'({prev_byte, b});
        if (!eof && lc_rejected(lc_field)) lc_error = 1'b1;
      end
      data_hit = p >= 7 && p <= 6 + lc_field && !lc_error;
    end
    if (data_hit && keep) begin
      r = '0;
      r.kind = KIND_DATA;
      r.payload = b;
      r.last = !eof;
      parsed_results.push_back(r);
    end
    if (eof) begin
      r = '0;
      r.kind = KIND_SUMMARY;
      r.cla = hdr_bytes[31:24];
      r.ins = hdr_bytes[23:16];
      r.p1 = hdr_bytes[15:8];
      r.p2 = hdr_bytes[7:0];
      r.last = 1'b1;
      flen = p + 1;
      bad = 1'b0;
      if (flen < 4) begin
        bad = 1'b1;
      end else if (flen == 5) begin
        r.le = 16'(b);
        r.le_present = 1'b1;
      end else if (flen > 5) begin
        if (!ext_form) begin
          if (lc_error || (flen != lc_field + 5 && flen != lc_field + 6)) bad = 1'b1;
          else begin
            r.lc = 16'(lc_field);
            if (flen == lc_field + 6) begin
              r.le = 16'(b);
              r.le_present = 1'b1;
            end
          end
        end else if (flen == 6) begin
          bad = 1'b1;
        end else if (flen == 7) begin
          r.le = {prev_byte, b};
          r.le_present = 1'b1;
        end else if (lc_error || (flen != lc_field + 7 && flen != lc_field + 9)) begin
          bad = 1'b1;
        end else begin
          r.lc = 16'(lc_field);
          if (flen == lc_field + 9) begin
            r.le = {prev_byte, b};
            r.le_present = 1'b1;
          end
        end
      end
      if (bad) begin
        r.le = '0;
        r.le_present = 1'b0;
        r.lc = flen < 6 ? 16'd0 : 16'(lc_field);
      end
      r.status = bad ? STATUS_WRONG : STATUS_OK;
      if (keep) parsed_results.push_back(r);
      frame_pos = 0;
      hdr_bytes = '0;
      ext_form = 1'b0;
      lc_field = 0;
      prev_byte = '0;
      lc_error = 1'b0;
    end else begin
      prev_byte = b;
      if (frame_pos < int'(POS_MAX)) frame_pos++;
    end
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eof, input bit typed,
                           input apdu_result_t literal);
    int gap;
    push <= 1'b1;
    in_byte <= b;
    frame_end <= eof;
    do @(posedge clk); while (full);
    parse_apdu_byte(b, eof, !typed);
    if (typed) parsed_results.push_back(literal);
    bytes_sent++;
    gap = idle_gap(tx_idle_pct);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, '0);
    frames_sent++;
  endtask

  task automatic wait_for_quiet();
    push <= 1'b0;
    while (parsed_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] value);
    logic [31:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MAX_LEN_ADDR;
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    max_len = value;
    limits_used++;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rd = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    compare_field("max_data_length", {16'd0, value}, rd);
  endtask

  function automatic int pick_lc(input bit ext);
    int lc;
    case ($urandom_range(0, 9))
      6: lc = int'(max_len);
      7: lc = int'(max_len) + 1;
      8: lc = ext ? $urandom_range(0, 65535) : $urandom_range(1, 255);
      9: lc = ext ? 0 : 255;
      default: lc = $urandom_range(1, 8);
    endcase
    if (ext) return lc > 65535 ? 65535 : lc;
    return lc < 1 ? 1 : (lc > 255 ? 255 : lc);
  endfunction

  // Cases: 0 = 1, 1 = 2S, 2 = 3S, 3 = 4S, 4 = 2E, 5 = 3E, 6 = 4E.
  task automatic build_frame();
    int pick;
    int lc;
    int count;
    bit ext;
    frame_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      count = pick < 5 ? $urandom_range(1, 3) : $urandom_range(4, 16);
      repeat (count) frame_q.push_back(8'($urandom));
    end else begin
      repeat (4) frame_q.push_back(8'($urandom));
      pick = $urandom_range(0, 6);
      ext = pick >= 4;
      if (pick == 1) frame_q.push_back(8'($urandom));
      if (pick == 4) begin
        frame_q.push_back(EXT_MARK);
        repeat (2) frame_q.push_back(8'($urandom));
      end
      if (pick == 2 || pick == 3 || pick >= 5) begin
        lc = pick_lc(ext);
        if (ext) begin
          frame_q.push_back(EXT_MARK);
          frame_q.push_back(8'(lc >> 8));
        end
        frame_q.push_back(8'(lc));
        if (lc <= 40 || (lc <= 300 && $urandom_range(0, 3) == 0)) count = lc;
        else count = $urandom_range(0, 20);
        repeat (count) frame_q.push_back(8'($urandom));
        if (pick == 3) frame_q.push_back(8'($urandom));
        if (pick == 6) repeat (2) frame_q.push_back(8'($urandom));
      end
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 1) void'(frame_q.pop_back());
        else frame_q.push_back(8'($urandom));
      end
    end
  endtask

  // result side: random pop gaps, plus two long hold-offs to back up the input
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 40 : 320)) begin
      pop <= 1'b0;
      hold_left = HOLD_CYCLES;
      holds_done++;
    end else if (rx_gap > 0) begin
      pop <= 1'b0;
      rx_gap--;
    end else begin
      pop <= 1'b1;
      rx_gap = idle_gap(rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    apdu_result_t want;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (parsed_results.size() == 0) begin
        $error("unexpected result transfer: kind %0b payload 0x%0h", kind, payload_byte);
        mismatches++;
      end else begin
        want = parsed_results.pop_front();
        compare_field("kind", 32'(want.kind), 32'(kind));
        compare_field("payload_byte", 32'(want.payload), 32'(payload_byte));
        compare_field("class_byte", 32'(want.cla), 32'(class_byte));
        compare_field("instruction_byte", 32'(want.ins), 32'(instruction_byte));
        compare_field("param_one", 32'(want.p1), 32'(param_one));
        compare_field("param_two", 32'(want.p2), 32'(param_two));
        compare_field("data_length", 32'(want.lc), 32'(data_length));
        compare_field("expected_length", 32'(want.le), 32'(expected_length));
        compare_field("expected_present", 32'(want.le_present), 32'(expected_present));
        compare_field("status", 32'(want.status), 32'(status));
        compare_field("last_result", 32'(want.last), 32'(last_result));
      end
    end
  end

  initial begin
    apdu_result_t lit;
    int phase_bytes;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    foreach (script_rows[i]) begin
      lit = '0;
      lit.kind = KIND_SUMMARY;
      lit.cla = script_rows[i].cla;
      lit.ins = script_rows[i].ins;
      lit.p1 = script_rows[i].p1;
      lit.p2 = script_rows[i].p2;
      lit.lc = script_rows[i].lc;
      lit.le = script_rows[i].le;
      lit.le_present = script_rows[i].lep;
      lit.status = script_rows[i].st;
      lit.last = 1'b1;
      send_byte(script_rows[i].b, script_rows[i].eof, script_rows[i].typed, lit);
      if (script_rows[i].eof) frames_sent++;
    end

    for (int phase = 0; phase < 6; phase++) begin
      wait_for_quiet();
      case (phase)
        1: write_max_len(16'd0);
        2: write_max_len(16'hFFFF);
        3: write_max_len(16'd1);
        4: write_max_len(16'($urandom_range(2, 300)));
        5: write_max_len(16'd255);
        default: ;
      endcase
      tx_idle_pct = phase == 2 ? 0 : $urandom_range(0, 3) * 20;
      rx_idle_pct = phase == 2 ? 0 : $urandom_range(0, 3) * 20;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        build_frame();
        phase_bytes += frame_q.size();
        send_frame();
      end
    end

    wait_for_quiet();
    $display("Covered %0d frames / %0d bytes under %0d length limits, %0d results checked,",
             frames_sent, bytes_sent, limits_used, results_seen);
    $display("with %0d long output hold-offs that backed up the input.", holds_done);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
